/* src/tnro_pkg.sv */
// ----------------------------------------------------------------------------
// tnro_pkg
// Shared constants, types and table helpers for the telnet receive option
// negotiator.
// ----------------------------------------------------------------------------
`default_nettype none

package tnro_pkg;

  // telnet command bytes
  localparam logic [7:0] T_IAC  = 8'd255;
  localparam logic [7:0] T_DONT = 8'd254;
  localparam logic [7:0] T_DO   = 8'd253;
  localparam logic [7:0] T_WONT = 8'd252;
  localparam logic [7:0] T_WILL = 8'd251;
  localparam logic [7:0] T_SB   = 8'd250;
  localparam logic [7:0] T_SE   = 8'd240;
  localparam logic [7:0] T_CR   = 8'd13;
  localparam logic [7:0] T_NUL  = 8'd0;

  localparam logic [7:0] OPT_NAWS = 8'd31;
  localparam logic [7:0] OPT_OENV = 8'd36;
  localparam logic [7:0] OPT_NENV = 8'd39;

  // input modes
  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_OPEN = 2'd1;
  localparam logic [1:0] MODE_URG  = 2'd2;
  localparam logic [1:0] MODE_SIZE = 2'd3;

  // result destinations
  localparam logic [1:0] DEST_TERM = 2'd0;
  localparam logic [1:0] DEST_NET  = 2'd1;
  localparam logic [1:0] DEST_SUB  = 2'd2;
  localparam logic [1:0] DEST_END  = 2'd3;

  // option negotiation states
  localparam logic [1:0] ST_REQ    = 2'd0;
  localparam logic [1:0] ST_ACT    = 2'd1;
  localparam logic [1:0] ST_INACT  = 2'd2;
  localparam logic [1:0] ST_RINACT = 2'd3;

  // parser states
  localparam logic [3:0] P_TOP    = 4'd0;
  localparam logic [3:0] P_IAC    = 4'd1;
  localparam logic [3:0] P_WILL   = 4'd2;
  localparam logic [3:0] P_WONT   = 4'd3;
  localparam logic [3:0] P_DO     = 4'd4;
  localparam logic [3:0] P_DONT   = 4'd5;
  localparam logic [3:0] P_SB     = 4'd6;
  localparam logic [3:0] P_SUB    = 4'd7;
  localparam logic [3:0] P_SUBIAC = 4'd8;
  localparam logic [3:0] P_CR     = 4'd9;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd1;

  localparam int SUBNEG_MAX = 1024;
  localparam int SUB_LEN_W  = 11;
  localparam int MAX_RES    = 21;
  localparam int BUF_DEPTH  = 32;
  localparam int PTR_W      = $clog2(BUF_DEPTH);

  // option table
  localparam int NOPT  = 8;
  localparam int OPT_W = $clog2(NOPT);
  localparam logic [7:0] TAB_CODE [NOPT] = '{8'd31, 8'd32, 8'd24, 8'd36,
                                             8'd39, 8'd1, 8'd3, 8'd3};
  // bit set: our side of the option (we send WILL/WONT)
  localparam logic [NOPT-1:0] TAB_WE = 8'b0101_1111;

  localparam logic [OPT_W-1:0] E_NAWS = 3'd0;
  localparam logic [OPT_W-1:0] E_OENV = 3'd3;
  localparam logic [OPT_W-1:0] E_NENV = 3'd4;

  // byte positions of a three-byte command
  localparam logic [1:0] S3_IAC = 2'd0;
  localparam logic [1:0] S3_CMD = 2'd1;
  localparam logic [1:0] S3_OPT = 2'd2;

  // NAWS burst: positions of the last byte and of the size bytes
  localparam logic [3:0] SZ_FIRST_DATA = 4'd3;
  localparam logic [3:0] SZ_LAST_DATA  = 4'd6;
  localparam logic [3:0] SZ_END        = 4'd8;

  typedef struct packed {
    logic [1:0]           dest;
    logic [7:0]           data_byte;
    logic [7:0]           sub_option;
    logic [SUB_LEN_W-1:0] sub_length;
  } res_t;

  typedef struct packed {
    logic       load;
    logic       exec;
    logic       neg;
    logic       onact;
    logic       open;
    logic       size;
    logic       s3;
    logic [1:0] s3_idx;
    logic       drain;
  } cmd_t;

  typedef struct packed {
    logic neg_go;
    logic open_go;
    logic size_go;
    logic need_s3;
    logic need_onact;
    logic need_size;
    logic scan_last;
    logic size_done;
    logic drain_done;
  } stat_t;

  function automatic logic [7:0] cmd_send(input logic [OPT_W-1:0] e);
    return TAB_WE[e] ? T_WILL : T_DO;
  endfunction

  function automatic logic [7:0] cmd_nsend(input logic [OPT_W-1:0] e);
    return TAB_WE[e] ? T_WONT : T_DONT;
  endfunction

endpackage

`default_nettype wire

/* src/tnro_in_if.sv */
// ----------------------------------------------------------------------------
// tnro_in_if
// Input event channel: mode and received byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface tnro_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

`default_nettype wire

/* src/tnro_out_if.sv */
// ----------------------------------------------------------------------------
// tnro_out_if
// Result channel: destination, byte and subnegotiation context.
// ----------------------------------------------------------------------------
`default_nettype none

interface tnro_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  dest;
  logic [7:0]  data_byte;
  logic [7:0]  sub_option;
  logic [10:0] sub_length;
  logic        last;

  modport source (output valid, output dest, output data_byte, output sub_option,
                  output sub_length, output last, input ready);
  modport sink   (input valid, input dest, input data_byte, input sub_option,
                  input sub_length, input last, output ready);
endinterface

`default_nettype wire

/* src/tnro_ctl.sv */
// ----------------------------------------------------------------------------
// tnro_ctl
// Sequencer: steps one event through parse, negotiation, command bursts
// and result drain.
// ----------------------------------------------------------------------------
`default_nettype none

module tnro_ctl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire tnro_pkg::stat_t stat,
  output tnro_pkg::cmd_t     cmd
);

  localparam logic [3:0] C_IDLE  = 4'd0;
  localparam logic [3:0] C_EXEC  = 4'd1;
  localparam logic [3:0] C_NEG   = 4'd2;
  localparam logic [3:0] C_ONACT = 4'd3;
  localparam logic [3:0] C_OPEN  = 4'd4;
  localparam logic [3:0] C_S3A   = 4'd5;
  localparam logic [3:0] C_S3B   = 4'd6;
  localparam logic [3:0] C_S3C   = 4'd7;
  localparam logic [3:0] C_SIZE  = 4'd8;
  localparam logic [3:0] C_DRAIN = 4'd9;

  logic [3:0] state, state_next;
  logic [3:0] ret, ret_next;
  logic [3:0] tgt;

  assign in_ready = (state == C_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    ret_next   = ret;
    tgt        = stat.scan_last ? C_DRAIN : C_OPEN;
    case (state)
      C_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = C_EXEC;
        end
      end
      C_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.neg_go) state_next = C_NEG;
        else if (stat.open_go) state_next = C_OPEN;
        else if (stat.size_go) state_next = C_SIZE;
        else state_next = C_DRAIN;
      end
      C_NEG: begin
        cmd.neg = 1'b1;
        if (stat.need_s3) begin
          state_next = C_S3A;
          ret_next   = stat.need_onact ? C_ONACT : C_DRAIN;
        end else if (stat.need_onact) begin
          state_next = C_ONACT;
        end else begin
          state_next = C_DRAIN;
        end
      end
      C_ONACT: begin
        cmd.onact = 1'b1;
        if (stat.need_s3) begin
          state_next = C_S3A;
          ret_next   = C_DRAIN;
        end else if (stat.need_size) begin
          state_next = C_SIZE;
        end else begin
          state_next = C_DRAIN;
        end
      end
      C_OPEN: begin
        cmd.open = 1'b1;
        if (stat.need_s3) begin
          state_next = C_S3A;
          ret_next   = tgt;
        end else begin
          state_next = tgt;
        end
      end
      C_S3A: begin
        cmd.s3     = 1'b1;
        cmd.s3_idx = tnro_pkg::S3_IAC;
        state_next = C_S3B;
      end
      C_S3B: begin
        cmd.s3     = 1'b1;
        cmd.s3_idx = tnro_pkg::S3_CMD;
        state_next = C_S3C;
      end
      C_S3C: begin
        cmd.s3     = 1'b1;
        cmd.s3_idx = tnro_pkg::S3_OPT;
        state_next = ret;
      end
      C_SIZE: begin
        cmd.size = 1'b1;
        if (stat.size_done) state_next = C_DRAIN;
      end
      C_DRAIN: begin
        cmd.drain = 1'b1;
        if (stat.drain_done) state_next = C_IDLE;
      end
      default: begin
        state_next = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      ret   <= C_DRAIN;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

endmodule

`default_nettype wire

/* src/tnro_dp.sv */
// ----------------------------------------------------------------------------
// tnro_dp
// Datapath: parser and option state, window size registers, command byte
// generation and the result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module tnro_dp (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [1:0]                     in_mode,
  input  wire logic [7:0]                     in_byte,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tnro_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                    cfg_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output tnro_pkg::res_t                      out_res,
  output logic                                out_last,
  input  wire tnro_pkg::cmd_t                 cmd,
  output tnro_pkg::stat_t                     stat
);

  localparam int PW = tnro_pkg::PTR_W;
  localparam int OW = tnro_pkg::OPT_W;
  localparam int LW = tnro_pkg::SUB_LEN_W;

  logic [1:0]  mode_q;
  logic [7:0]  byte_q;
  logic [15:0] cols, rows;

  logic [3:0]    pst, pst_next;
  logic [7:0]    sopt, sopt_next;
  logic [LW-1:0] cnt, cnt_next;
  logic [1:0]    opt_st [tnro_pkg::NOPT];
  logic [1:0]    opt_next [tnro_pkg::NOPT];

  logic [7:0]    s3_cmd, s3_cmd_next, s3_opt, s3_opt_next;
  logic [OW-1:0] act_e, act_e_next;
  logic [OW-1:0] scan, scan_next;
  logic [3:0]    size_j, size_j_next;
  logic          dup, dup_next;

  tnro_pkg::res_t buf_mem [tnro_pkg::BUF_DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic           push;
  tnro_pkg::res_t push_word;

  // negotiation lookup
  logic [7:0]    neg_cmd;
  logic          neg_we, neg_pos, mf;
  logic [OW-1:0] me;
  logic [OW-1:0] off_e;
  logic [7:0]    size_byte;
  logic          need_s3, need_onact;

  assign cfg_ready = 1'b1;

  always_comb begin
    case (pst)
      tnro_pkg::P_WILL: neg_cmd = tnro_pkg::T_WILL;
      tnro_pkg::P_WONT: neg_cmd = tnro_pkg::T_WONT;
      tnro_pkg::P_DO:   neg_cmd = tnro_pkg::T_DO;
      default:          neg_cmd = tnro_pkg::T_DONT;
    endcase
    neg_we  = (pst == tnro_pkg::P_DO) || (pst == tnro_pkg::P_DONT);
    neg_pos = (pst == tnro_pkg::P_DO) || (pst == tnro_pkg::P_WILL);
    mf = 1'b0;
    me = '0;
    // descending so the lowest matching entry wins
    for (int i = tnro_pkg::NOPT - 1; i >= 0; i--) begin
      if (tnro_pkg::TAB_CODE[i] == byte_q && tnro_pkg::TAB_WE[i] == neg_we) begin
        mf = 1'b1;
        me = OW'(i);
      end
    end
  end

  always_comb begin
    case (size_j)
      4'd0:    size_byte = tnro_pkg::T_IAC;
      4'd1:    size_byte = tnro_pkg::T_SB;
      4'd2:    size_byte = tnro_pkg::OPT_NAWS;
      4'd3:    size_byte = cols[15:8];
      4'd4:    size_byte = cols[7:0];
      4'd5:    size_byte = rows[15:8];
      4'd6:    size_byte = rows[7:0];
      4'd7:    size_byte = tnro_pkg::T_IAC;
      default: size_byte = tnro_pkg::T_SE;
    endcase
  end

  assign off_e = (act_e == tnro_pkg::E_NENV) ? tnro_pkg::E_OENV : tnro_pkg::E_NENV;

  always_comb begin
    pst_next    = pst;
    sopt_next   = sopt;
    cnt_next    = cnt;
    opt_next    = opt_st;
    s3_cmd_next = s3_cmd;
    s3_opt_next = s3_opt;
    act_e_next  = act_e;
    scan_next   = scan;
    size_j_next = size_j;
    dup_next    = dup;
    need_s3     = 1'b0;
    need_onact  = 1'b0;
    push        = 1'b0;
    push_word   = '{dest: tnro_pkg::DEST_NET, data_byte: 8'd0, sub_option: 8'd0,
                    sub_length: '0};

    if (cmd.load) begin
      scan_next   = '0;
      size_j_next = '0;
      dup_next    = 1'b0;
    end

    if (cmd.exec) begin
      if (mode_q == tnro_pkg::MODE_URG) begin
        pst_next = tnro_pkg::P_TOP;
      end else if (mode_q == tnro_pkg::MODE_BYTE) begin
        case (pst)
          tnro_pkg::P_IAC: begin
            case (byte_q)
              tnro_pkg::T_DO:   pst_next = tnro_pkg::P_DO;
              tnro_pkg::T_DONT: pst_next = tnro_pkg::P_DONT;
              tnro_pkg::T_WILL: pst_next = tnro_pkg::P_WILL;
              tnro_pkg::T_WONT: pst_next = tnro_pkg::P_WONT;
              tnro_pkg::T_SB:   pst_next = tnro_pkg::P_SB;
              default:          pst_next = tnro_pkg::P_TOP;
            endcase
          end
          tnro_pkg::P_WILL, tnro_pkg::P_WONT, tnro_pkg::P_DO, tnro_pkg::P_DONT: begin
            pst_next = pst; // handled in the negotiation step
          end
          tnro_pkg::P_SB: begin
            sopt_next = byte_q;
            cnt_next  = '0;
            pst_next  = tnro_pkg::P_SUB;
          end
          tnro_pkg::P_SUB, tnro_pkg::P_SUBIAC: begin
            if (pst == tnro_pkg::P_SUB && byte_q == tnro_pkg::T_IAC) begin
              pst_next = tnro_pkg::P_SUBIAC;
            end else if (pst == tnro_pkg::P_SUBIAC && byte_q == tnro_pkg::T_SE) begin
              push      = 1'b1;
              push_word = '{dest: tnro_pkg::DEST_END, data_byte: 8'd0,
                            sub_option: sopt, sub_length: cnt};
              pst_next  = tnro_pkg::P_TOP;
            end else begin
              // payload byte, dropped once the count saturates
              if (cnt < LW'(tnro_pkg::SUBNEG_MAX)) begin
                cnt_next  = cnt + LW'(1);
                push      = 1'b1;
                push_word = '{dest: tnro_pkg::DEST_SUB, data_byte: byte_q,
                              sub_option: sopt, sub_length: cnt + LW'(1)};
              end
              pst_next = tnro_pkg::P_SUB;
            end
          end
          default: begin
            if (byte_q == tnro_pkg::T_NUL && pst == tnro_pkg::P_CR) begin
              pst_next = tnro_pkg::P_TOP;
            end else if (byte_q == tnro_pkg::T_IAC) begin
              pst_next = tnro_pkg::P_IAC;
            end else begin
              push      = 1'b1;
              push_word = '{dest: tnro_pkg::DEST_TERM, data_byte: byte_q,
                            sub_option: 8'd0, sub_length: '0};
              pst_next  = (byte_q == tnro_pkg::T_CR) ? tnro_pkg::P_CR : tnro_pkg::P_TOP;
            end
          end
        endcase
      end
    end

    if (cmd.neg) begin
      pst_next    = tnro_pkg::P_TOP;
      s3_opt_next = byte_q;
      act_e_next  = me;
      if (!mf) begin
        if (neg_cmd == tnro_pkg::T_WILL) begin
          need_s3     = 1'b1;
          s3_cmd_next = tnro_pkg::T_DONT;
        end else if (neg_cmd == tnro_pkg::T_DO) begin
          need_s3     = 1'b1;
          s3_cmd_next = tnro_pkg::T_WONT;
        end
      end else if (neg_pos) begin
        case (opt_st[me])
          tnro_pkg::ST_REQ: begin
            opt_next[me] = tnro_pkg::ST_ACT;
            need_onact   = tnro_pkg::TAB_WE[me];
          end
          tnro_pkg::ST_INACT: begin
            opt_next[me] = tnro_pkg::ST_ACT;
            need_s3      = 1'b1;
            s3_cmd_next  = tnro_pkg::cmd_send(me);
            need_onact   = tnro_pkg::TAB_WE[me];
          end
          tnro_pkg::ST_RINACT: begin
            need_s3     = 1'b1;
            s3_cmd_next = tnro_pkg::cmd_nsend(me);
          end
          default: begin
          end
        endcase
      end else begin
        if (opt_st[me] == tnro_pkg::ST_REQ) begin
          opt_next[me] = tnro_pkg::ST_INACT;
          // new environ refused: fall back to the old variant
          if (me == tnro_pkg::E_NENV && opt_st[tnro_pkg::E_OENV] == tnro_pkg::ST_INACT) begin
            need_s3                     = 1'b1;
            s3_cmd_next                 = tnro_pkg::T_WILL;
            s3_opt_next                 = tnro_pkg::OPT_OENV;
            opt_next[tnro_pkg::E_OENV]  = tnro_pkg::ST_REQ;
          end
        end else if (opt_st[me] == tnro_pkg::ST_ACT) begin
          opt_next[me] = tnro_pkg::ST_INACT;
          need_s3      = 1'b1;
          s3_cmd_next  = tnro_pkg::cmd_nsend(me);
        end
      end
    end

    if (cmd.onact) begin
      // one environ variant turns the other off
      if (act_e == tnro_pkg::E_NENV || act_e == tnro_pkg::E_OENV) begin
        if (opt_st[off_e] == tnro_pkg::ST_REQ || opt_st[off_e] == tnro_pkg::ST_ACT) begin
          need_s3     = 1'b1;
          s3_cmd_next = tnro_pkg::T_WONT;
          s3_opt_next = tnro_pkg::TAB_CODE[off_e];
        end
        opt_next[off_e] = tnro_pkg::ST_RINACT;
      end
    end

    if (cmd.open) begin
      scan_next = scan + OW'(1);
      if (opt_st[scan] == tnro_pkg::ST_REQ) begin
        need_s3     = 1'b1;
        s3_cmd_next = tnro_pkg::cmd_send(scan);
        s3_opt_next = tnro_pkg::TAB_CODE[scan];
      end
    end

    if (cmd.s3) begin
      push = 1'b1;
      case (cmd.s3_idx)
        tnro_pkg::S3_IAC: push_word.data_byte = tnro_pkg::T_IAC;
        tnro_pkg::S3_CMD: push_word.data_byte = s3_cmd;
        default:          push_word.data_byte = s3_opt;
      endcase
    end

    if (cmd.size) begin
      push                = 1'b1;
      push_word.data_byte = size_byte;
      if (size_j >= tnro_pkg::SZ_FIRST_DATA && size_j <= tnro_pkg::SZ_LAST_DATA &&
          size_byte == tnro_pkg::T_IAC && !dup) begin
        dup_next = 1'b1;
      end else begin
        dup_next    = 1'b0;
        size_j_next = size_j + 4'd1;
      end
    end
  end

  assign out_valid = cmd.drain && (rd_ptr != wr_ptr);
  assign out_res   = buf_mem[rd_ptr];
  assign out_last  = (rd_ptr + PW'(1)) == wr_ptr;

  always_comb begin
    stat            = '0;
    stat.neg_go     = (mode_q == tnro_pkg::MODE_BYTE) &&
                      (pst == tnro_pkg::P_WILL || pst == tnro_pkg::P_WONT ||
                       pst == tnro_pkg::P_DO || pst == tnro_pkg::P_DONT);
    stat.open_go    = (mode_q == tnro_pkg::MODE_OPEN);
    stat.size_go    = (mode_q == tnro_pkg::MODE_SIZE) &&
                      (opt_st[tnro_pkg::E_NAWS] == tnro_pkg::ST_ACT);
    stat.need_s3    = need_s3;
    stat.need_onact = need_onact;
    stat.need_size  = (act_e == tnro_pkg::E_NAWS);
    stat.scan_last  = (scan == OW'(tnro_pkg::NOPT - 1));
    stat.size_done  = (size_j == tnro_pkg::SZ_END);
    stat.drain_done = cmd.drain && ((rd_ptr == wr_ptr) || (out_ready && out_last));
  end

  always_ff @(posedge clk) begin
    if (push) buf_mem[wr_ptr] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= in_mode;
      byte_q <= in_byte;
    end
    s3_cmd <= s3_cmd_next;
    s3_opt <= s3_opt_next;
    act_e  <= act_e_next;
    scan   <= scan_next;
    size_j <= size_j_next;
    dup    <= dup_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cols   <= 16'd80;
      rows   <= 16'd24;
      pst    <= tnro_pkg::P_TOP;
      sopt   <= 8'd0;
      cnt    <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      for (int i = 0; i < tnro_pkg::NOPT; i++)
        opt_st[i] <= (i == int'(tnro_pkg::E_OENV)) ? tnro_pkg::ST_INACT : tnro_pkg::ST_REQ;
    end else begin
      if (cfg_valid && cfg_index == tnro_pkg::CFG_COLS) cols <= cfg_data;
      if (cfg_valid && cfg_index == tnro_pkg::CFG_ROWS) rows <= cfg_data;
      pst    <= pst_next;
      sopt   <= sopt_next;
      cnt    <= cnt_next;
      opt_st <= opt_next;
      if (cmd.load) begin
        wr_ptr <= '0;
        rd_ptr <= '0;
      end else begin
        if (push) wr_ptr <= wr_ptr + PW'(1);
        if (out_valid && out_ready) rd_ptr <= rd_ptr + PW'(1);
      end
    end
  end

  a_buf_bound: assert property (@(posedge clk) disable iff (rst)
    wr_ptr <= PW'(tnro_pkg::MAX_RES))
    else $error("result buffer over its bound");

  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (wr_ptr == '0 && rd_ptr == '0))
    else $error("buffer not cleared on new word");

  a_cnt_sat: assert property (@(posedge clk) disable iff (rst)
    cnt <= LW'(tnro_pkg::SUBNEG_MAX))
    else $error("subnegotiation count past saturation");

  a_env_excl: assert property (@(posedge clk) disable iff (rst)
    !(opt_st[tnro_pkg::E_OENV] == tnro_pkg::ST_ACT &&
      opt_st[tnro_pkg::E_NENV] == tnro_pkg::ST_ACT))
    else $error("both environ variants active");

endmodule

`default_nettype wire

/* src/telnet_receive_option_negotiator.sv */
// ----------------------------------------------------------------------------
// telnet_receive_option_negotiator
// Telnet receive parser with option negotiation and NAWS reporting.
// ----------------------------------------------------------------------------
// One event is taken at a time. Each event is loaded and parsed; a
// WILL/WONT/DO/DONT then gets an option table lookup (and a follow-up step
// when the new option state triggers one), a connection open scans every
// option table entry, and the generated network bytes are built one by one.
// Results are built into a 32-entry buffer and then drained in order; the
// next event is accepted once the last word of the current one has been
// taken (or once the drain finds none). Received data bytes give at most one
// result; a negotiation gives up to 16 and a connection open up to 21.
`default_nettype none

module telnet_receive_option_negotiator (
  input  wire logic                           clk,
  input  wire logic                           rst,
  tnro_in_if.sink                             in_ch,
  tnro_out_if.source                          out_ch,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tnro_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                    cfg_data
);

  tnro_pkg::cmd_t  cmd;
  tnro_pkg::stat_t stat;
  tnro_pkg::res_t  res;
  logic            in_ready;
  logic            out_valid;
  logic            out_last;

  tnro_ctl u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tnro_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_mode   (in_ch.mode),
    .in_byte   (in_ch.rx_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_res   (res),
    .out_last  (out_last),
    .cmd       (cmd),
    .stat      (stat)
  );

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid;
  assign out_ch.dest       = res.dest;
  assign out_ch.data_byte  = res.data_byte;
  assign out_ch.sub_option = res.sub_option;
  assign out_ch.sub_length = res.sub_length;
  assign out_ch.last       = out_last;

endmodule

`default_nettype wire
